>>> rtl/bsda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsda_pkg;

   localparam int MODE_W   = 3;
   localparam int POS_W    = 4;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH      = 3'd0,
      MODE_POP       = 3'd1,
      MODE_PEEK      = 3'd2,
      MODE_OVERWRITE = 3'd3,
      MODE_CLEAR     = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

endpackage

`default_nettype wire

>>> rtl/bsda_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bsda_req_if;
   logic                         valid;
   logic                         ready;
   logic [bsda_pkg::MODE_W-1:0]  mode;
   logic [bsda_pkg::POS_W-1:0]   position;
   logic [bsda_pkg::VALUE_W-1:0] value;

   modport source (output valid, output mode, output position, output value, input ready);
   modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface bsda_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bsda_pkg::STATUS_W-1:0] status;
   logic [bsda_pkg::VALUE_W-1:0]  read_value;
   logic [bsda_pkg::COUNT_W-1:0]  entry_count;
   logic                          is_full;
   logic                          is_empty;

   modport source (output valid, output status, output read_value, output entry_count,
                   output is_full, output is_empty, input ready);
   modport sink   (input valid, input status, input read_value, input entry_count,
                   input is_full, input is_empty, output ready);
endinterface

`default_nettype wire

>>> rtl/bounded_stack_with_depth_access_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  transaction
// req_if    in         mode, position, value
// rsp_if    out        status, read_value, entry_count, is_full, is_empty
//
// one request per cycle sustained while responses are taken; a response is presented from
// the output register: the entry read and the request stage load as the request is taken,
// the output register loads from the request stage once the output is free.
// the count register is updated as a request is taken, so the next request sees it.
// reset clears the count and the valid flags; entry contents stay as they were.
// a stalled response holds one request in the middle stage, then req_if.ready drops.

module bounded_stack_with_depth_access_unit #(
   parameter int DEPTH      = 8,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bsda_req_if.sink    req_if,
   bsda_rsp_if.source  rsp_if
);

   import bsda_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int CW    = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_ff;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pend_valid_ff, pend_valid_in;
   status_type         pend_status_ff, pend_status_in;
   logic               pend_peek_ff, pend_peek_in;
   logic [CNT_W-1:0]   pend_count_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [VALUE_W-1:0] rsp_read_value_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_full_ff;
   logic               rsp_empty_ff;

   logic               out_free;
   logic               req_ready;
   logic               accept;
   logic               move;
   logic               pos_ok;
   logic               is_full_now;
   logic               is_empty_now;
   logic [CMP_W-1:0]   depth_diff;
   logic               mem_we;
   logic               mem_re;
   logic [IDX_W-1:0]   mem_addr;
   logic [DATA_WIDTH-1:0] mem_wdata;

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign req_ready = !pend_valid_ff || out_free;
   assign accept    = req_if.valid && req_ready;
   assign move      = pend_valid_ff && out_free;

   assign is_full_now  = (count_ff == CNT_W'(DEPTH));
   assign is_empty_now = (count_ff == '0);
   assign pos_ok       = (req_if.position != '0) &&
                         (CMP_W'(req_if.position) <= CMP_W'(count_ff));
   // entry index of a position counted down from the top
   assign depth_diff   = CMP_W'(count_ff) - CMP_W'(req_if.position);
   assign mem_wdata    = DATA_WIDTH'(req_if.value[CW-1:0]);

   always_comb begin
      count_in       = count_ff;
      pend_status_in = ST_OK;
      pend_peek_in   = 1'b0;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_addr       = depth_diff[IDX_W-1:0];
      unique case (req_if.mode)
         MODE_PUSH: begin
            mem_addr = count_ff[IDX_W-1:0];
            if (is_full_now) begin
               pend_status_in = ST_FULL;
            end else begin
               mem_we   = accept;
               count_in = count_ff + 1'b1;
            end
         end
         MODE_POP: begin
            if (is_empty_now) begin
               pend_status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         MODE_PEEK: begin
            if (is_empty_now) begin
               pend_status_in = ST_EMPTY;
            end else if (!pos_ok) begin
               pend_status_in = ST_RANGE;
            end else begin
               mem_re       = accept;
               pend_peek_in = 1'b1;
            end
         end
         MODE_OVERWRITE: begin
            if (is_empty_now) begin
               pend_status_in = ST_EMPTY;
            end else if (!pos_ok) begin
               pend_status_in = ST_RANGE;
            end else begin
               mem_we = accept;
            end
         end
         MODE_CLEAR: begin
            count_in = '0;
         end
         default: begin
            // unused codes do nothing
         end
      endcase
   end

   assign pend_valid_in = accept || (pend_valid_ff && !out_free);
   assign rsp_valid_in  = out_free ? pend_valid_ff : rsp_valid_ff;

   // entry memory, one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_status_ff <= pend_status_in;
         pend_peek_ff   <= pend_peek_in;
         pend_count_ff  <= count_in;
      end
      if (move) begin
         rsp_status_ff     <= pend_status_ff;
         rsp_read_value_ff <= pend_peek_ff ? VALUE_W'(rd_ff[CW-1:0]) : '0;
         rsp_count_ff      <= COUNT_W'(pend_count_ff);
         rsp_full_ff       <= (pend_count_ff == CNT_W'(DEPTH));
         rsp_empty_ff      <= (pend_count_ff == '0);
      end
   end

   assign req_if.ready       = req_ready;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.read_value  = rsp_read_value_ff;
   assign rsp_if.entry_count = rsp_count_ff;
   assign rsp_if.is_full     = rsp_full_ff;
   assign rsp_if.is_empty    = rsp_empty_ff;

endmodule

`default_nettype wire
